/* src/mic_pkg.sv */
// shared constants, types and width helpers for the 3x3 matrix inverse
// no dependencies; imported by every module of the block
package mic_pkg;

  localparam int NUM_ELEM  = 9;
  localparam int THR_WIDTH = 31;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 31'd7;

  // operand elements (a, b, c, d) of each cofactor a*b - c*d, row-major adjugate order
  localparam int COF_IDX [NUM_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // control that travels from the front end into the divider array
  typedef struct packed {
    logic                valid;
    logic                singular;
    logic [NUM_ELEM-1:0] neg;
  } front_ctl_t;

  // signed determinant width
  function automatic int det_width(int w);
    return 3 * w + 2;
  endfunction

  // doubled determinant magnitude width
  function automatic int den_width(int w);
    return 3 * w + 3;
  endfunction

  // rounding numerator width: (|cof| << (2f+1)) + |det|
  function automatic int num_width(int w, int f);
    int a;
    int b;
    a = 2 * w + 1 + 2 * f + 1;
    b = 3 * w + 2;
    return ((a > b) ? a : b) + 1;
  endfunction

  // partial remainder width of the divider
  function automatic int rem_width(int w, int f);
    int a;
    int b;
    a = num_width(w, f);
    b = den_width(w) + w;
    return ((a > b) ? a : b) + 1;
  endfunction

endpackage

/* src/mic_front.sv */
// front end: products, cofactors, determinant, singular test, divider operands
// depends on mic_pkg
module mic_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic signed [W-1:0]      mat_i [mic_pkg::NUM_ELEM],
  input  logic [mic_pkg::THR_WIDTH-1:0] thr_i,
  output mic_pkg::front_ctl_t      ctl_o,
  output logic [mic_pkg::num_width(W, F)-1:0] num_o [mic_pkg::NUM_ELEM],
  output logic [mic_pkg::den_width(W)-1:0]    den2_o
);
  import mic_pkg::*;

  localparam int PW   = 2 * W;
  localparam int CW   = 2 * W + 1;
  localparam int DETW = det_width(W);
  localparam int DW   = den_width(W);
  localparam int NW   = num_width(W, F);
  localparam int TW   = THR_WIDTH + 2 * F;
  localparam int CMPW = (DETW > TW) ? DETW : TW;

  logic [5:0] v_r;

  logic signed [PW-1:0]   pa_r [NUM_ELEM];
  logic signed [PW-1:0]   pb_r [NUM_ELEM];
  logic signed [W-1:0]    row1_r [3];
  logic signed [W-1:0]    row2_r [3];
  logic signed [CW-1:0]   cof_r  [NUM_ELEM];
  logic signed [CW-1:0]   cof3_r [NUM_ELEM];
  logic signed [CW-1:0]   cof4_r [NUM_ELEM];
  logic signed [CW-1:0]   lo_r [3];
  logic signed [CW-1:0]   hi_r [3];
  logic signed [DETW-1:0] det_r;
  logic [DETW-1:0]        dmag_r;
  logic                   dneg_r;
  logic [CW-1:0]          cmag_r [NUM_ELEM];
  logic [NUM_ELEM-1:0]    cneg_r;
  logic                   sing_r;
  logic [NUM_ELEM-1:0]    neg_r;
  logic [NW-1:0]          num_r [NUM_ELEM];
  logic [DW-1:0]          den2_r;
  logic signed [DETW-1:0] det_nxt;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  // stage 1: the eighteen element products; stage 2: cofactors
  for (genvar g = 0; g < NUM_ELEM; g++) begin : g_cof
    always_ff @(posedge clk) begin
      if (adv) begin
        pa_r[g]   <= PW'(mat_i[COF_IDX[g][0]]) * PW'(mat_i[COF_IDX[g][1]]);
        pb_r[g]   <= PW'(mat_i[COF_IDX[g][2]]) * PW'(mat_i[COF_IDX[g][3]]);
        cof_r[g]  <= CW'(pa_r[g]) - CW'(pb_r[g]);
        cof3_r[g] <= cof_r[g];
        cof4_r[g] <= cof3_r[g];
      end
    end
  end

  // stage 3: first-row element times its cofactor, split into two halves
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (adv) begin
        row1_r[j] <= mat_i[j];
        row2_r[j] <= row1_r[j];
        lo_r[j]   <= CW'(row2_r[j]) * CW'($signed({1'b0, cof_r[3*j][W-1:0]}));
        hi_r[j]   <= CW'(row2_r[j]) * CW'($signed(cof_r[3*j][CW-1:W]));
      end
    end
  end

  // stage 4: determinant sum
  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt + (DETW'(hi_r[j]) <<< W) + DETW'(lo_r[j]);
    end
  end

  // stages 4 and 5: determinant, then magnitudes and signs
  always_ff @(posedge clk) begin
    if (adv) begin
      det_r  <= det_nxt;
      dneg_r <= det_r[DETW-1];
      dmag_r <= det_r[DETW-1] ? DETW'(-det_r) : DETW'(det_r);
      for (int g = 0; g < NUM_ELEM; g++) begin
        cneg_r[g] <= cof4_r[g][CW-1];
        cmag_r[g] <= cof4_r[g][CW-1] ? CW'(-cof4_r[g]) : CW'(cof4_r[g]);
      end
    end
  end

  // stage 6: singular test and rounding operands
  always_ff @(posedge clk) begin
    if (adv) begin
      sing_r <= CMPW'(dmag_r) <= CMPW'({thr_i, {(2*F){1'b0}}});
      den2_r <= {dmag_r, 1'b0};
      for (int g = 0; g < NUM_ELEM; g++) begin
        num_r[g] <= (NW'(cmag_r[g]) << (2 * F + 1)) + NW'(dmag_r);
        neg_r[g] <= cneg_r[g] ^ dneg_r;
      end
    end
  end

  assign ctl_o.valid    = v_r[5];
  assign ctl_o.singular = sing_r;
  assign ctl_o.neg      = neg_r;
  assign num_o          = num_r;
  assign den2_o         = den2_r;

endmodule

/* src/mic_div.sv */
// divider array: nine restoring dividers, one quotient bit per stage, then round/saturate
// depends on mic_pkg
module mic_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  mic_pkg::front_ctl_t ctl_i,
  input  logic [mic_pkg::num_width(W, F)-1:0] num_i [mic_pkg::NUM_ELEM],
  input  logic [mic_pkg::den_width(W)-1:0]    den2_i,
  output logic                valid_o,
  output logic                invertible_o,
  output logic                saturated_o,
  output logic [W-1:0]        res_o [mic_pkg::NUM_ELEM]
);
  import mic_pkg::*;

  localparam int DW = den_width(W);
  localparam int RW = rem_width(W, F);
  localparam int S  = W + 2;

  logic [S-1:0]          v_r;
  logic [RW-1:0]         rem_r [W+1][NUM_ELEM];
  logic [W-1:0]          q_r   [W+1][NUM_ELEM];
  logic [NUM_ELEM-1:0]   ovf_r [W+1];
  logic [NUM_ELEM-1:0]   neg_r [W+1];
  logic                  sing_r [W+1];
  logic [DW-1:0]         den_r  [W+1];
  logic [W-1:0]          res_r [NUM_ELEM];
  logic                  inv_r;
  logic                  sat_r;
  logic [W-1:0]          res_nxt [NUM_ELEM];
  logic                  sat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[S-2:0], ctl_i.valid};
    end
  end

  // stage 0: quotient too large for W bits
  always_ff @(posedge clk) begin
    if (adv) begin
      sing_r[0] <= ctl_i.singular;
      neg_r[0]  <= ctl_i.neg;
      den_r[0]  <= den2_i;
      for (int l = 0; l < NUM_ELEM; l++) begin
        rem_r[0][l] <= RW'(num_i[l]);
        q_r[0][l]   <= '0;
        ovf_r[0][l] <= RW'(num_i[l]) >= (RW'(den2_i) << W);
      end
    end
  end

  // stages 1..W: one quotient bit each, most significant first
  for (genvar s = 1; s <= W; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        sing_r[s] <= sing_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        den_r[s]  <= den_r[s-1];
      end
    end
    for (genvar l = 0; l < NUM_ELEM; l++) begin : g_lane
      logic [RW-1:0] trial;
      assign trial = rem_r[s-1][l] - (RW'(den_r[s-1]) << (W - s));
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[s][l] <= trial[RW-1] ? rem_r[s-1][l] : trial;
          q_r[s][l]   <= q_r[s-1][l] | (W'(!trial[RW-1]) << (W - s));
        end
      end
    end
  end

  // sign, saturation and singular zeroing
  always_comb begin
    logic pos_sat;
    logic neg_sat;
    logic [W-1:0] q;
    sat_nxt = 1'b0;
    for (int l = 0; l < NUM_ELEM; l++) begin
      q       = q_r[W][l];
      pos_sat = !neg_r[W][l] && (ovf_r[W][l] || q[W-1]);
      neg_sat = neg_r[W][l] && (ovf_r[W][l] || (q[W-1] && (|q[W-2:0])));
      if (sing_r[W]) begin
        res_nxt[l] = '0;
      end else if (pos_sat) begin
        res_nxt[l] = {1'b0, {(W-1){1'b1}}};
      end else if (neg_sat) begin
        res_nxt[l] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res_nxt[l] = neg_r[W][l] ? W'(-q) : q;
      end
      sat_nxt = sat_nxt | (!sing_r[W] && (pos_sat || neg_sat));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
      inv_r <= !sing_r[W];
    end
  end

  assign valid_o      = v_r[S-1];
  assign invertible_o = inv_r;
  assign saturated_o  = sat_r;
  assign res_o        = res_r;

endmodule

/* src/matrix3_inverse_cofactor.sv */
// top level of the 3x3 fixed-point matrix inverse by adjugate and determinant
// depends on mic_pkg, mic_front, mic_div
//
// Takes one matrix beat per clock while in_tready is high and returns its
// inverse: six front-end stages for products, cofactors and determinant,
// ELEM_WIDTH + 2 divider stages in nine parallel lanes (overflow test, one
// quotient bit per stage, sign and saturation), one output register. The
// pipeline advances as a whole; a one-beat skid register behind it lets the
// output stall while one more beat lands, and in_tready drops only once that
// skid register holds a beat. A determinant whose magnitude is at or below
// the threshold (Q15.16) gives invertible = 0 and an all-zero beat.
module matrix3_inverse_cofactor #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero pad
  input  logic [((mic_pkg::NUM_ELEM*ELEM_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, zero pad
  output logic [((mic_pkg::NUM_ELEM*ELEM_WIDTH+7)/8)*8-1:0] out_tdata,
  // invertible, saturated
  output logic [1:0] out_tuser,
  input  logic cfg_wr_en,
  input  logic [mic_pkg::THR_WIDTH-1:0] cfg_wr_data
);
  import mic_pkg::*;

  localparam int W   = ELEM_WIDTH;
  localparam int TDW = ((NUM_ELEM * W + 7) / 8) * 8;

  logic [THR_WIDTH-1:0]   thr_r;
  logic                   adv;
  logic signed [W-1:0]    mat [NUM_ELEM];
  front_ctl_t             fctl;
  logic [num_width(W, FRAC_BITS)-1:0] num [NUM_ELEM];
  logic [den_width(W)-1:0] den2;
  logic                   p_valid;
  logic                   p_inv;
  logic                   p_sat;
  logic [W-1:0]           p_res [NUM_ELEM];
  logic [TDW-1:0]         p_tdata;
  logic                   out_v_r;
  logic [TDW-1:0]         out_d_r;
  logic [1:0]             out_u_r;
  logic                   skid_v_r;
  logic [TDW-1:0]         skid_d_r;
  logic [1:0]             skid_u_r;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // pipeline moves whenever the skid register is empty
  assign adv       = !skid_v_r;
  assign in_tready = adv;

  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_unpack
    assign mat[i] = $signed(in_tdata[i*W +: W]);
  end

  mic_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .mat_i    (mat),
    .thr_i    (thr_r),
    .ctl_o    (fctl),
    .num_o    (num),
    .den2_o   (den2)
  );

  mic_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .ctl_i        (fctl),
    .num_i        (num),
    .den2_i       (den2),
    .valid_o      (p_valid),
    .invertible_o (p_inv),
    .saturated_o  (p_sat),
    .res_o        (p_res)
  );

  // pack the result beat
  always_comb begin
    p_tdata = '0;
    for (int i = 0; i < NUM_ELEM; i++) begin
      p_tdata[i*W +: W] = p_res[i];
    end
  end

  // output register with one-beat skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (adv) begin
      if (p_valid) begin
        if (!out_v_r || out_tready) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end else if (out_tready) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (p_valid) begin
        if (!out_v_r || out_tready) begin
          out_d_r <= p_tdata;
          out_u_r <= {p_sat, p_inv};
        end else begin
          skid_d_r <= p_tdata;
          skid_u_r <= {p_sat, p_inv};
        end
      end
    end else if (out_tready) begin
      out_d_r <= skid_d_r;
      out_u_r <= skid_u_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;

endmodule

/* src/mic_chk.sv */
// port-level checks for matrix3_inverse_cofactor, bound to the top level
// depends on mic_pkg
module mic_chk #(
  parameter int ELEM_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((mic_pkg::NUM_ELEM*ELEM_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic [1:0] out_tuser
);
  import mic_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a singular beat carries only zeros
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("singular beat not cleared");

  // saturation is only flagged on an invertible matrix
  a_sat_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("saturated flag on singular beat");

  // input back-pressure only follows an output stall
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output stall");

endmodule

bind matrix3_inverse_cofactor mic_chk #(.ELEM_WIDTH(ELEM_WIDTH)) u_mic_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* tb/sv/matrix3_inverse_cofactor_tb.sv */
// self-checking bench for the 3x3 fixed-point matrix inverse
// computes each expected inverse exactly with wide integers; depends on mic_pkg
module matrix3_inverse_cofactor_tb;
  import mic_pkg::*;

  localparam int EW = 32;
  localparam int FB = 16;
  localparam int DW = ((NUM_ELEM*EW+7)/8)*8;
  localparam int LATENCY = EW + 9;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [EW-1:0] elem_t;
  typedef elem_t mat_t [NUM_ELEM];
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic invertible;
    logic saturated;
    elem_t inv [NUM_ELEM];
  } inverse_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [DW-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_wr_en = 0;
  logic [THR_WIDTH-1:0] cfg_wr_data = '0;

  matrix3_inverse_cofactor uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  logic [DW-1:0] pending_beats [$];
  inverse_t expected_inverses [$];
  logic [THR_WIDTH-1:0] threshold = THR_RESET;
  int errors = 0;
  int cycles = 0;
  int n_sent = 0, n_recv = 0, n_singular = 0, n_sat = 0;
  int hold_off = 0;
  bit long_hold_done = 0;
  int in_gap = 0, out_gap = 0;
  bit stimulus_done = 0;

  // exact adjugate / determinant with rounded, saturated quotients
  function automatic inverse_t invert_matrix(mat_t m, logic [THR_WIDTH-1:0] thr);
    inverse_t r;
    wide_t w [NUM_ELEM];
    wide_t cof [NUM_ELEM];
    wide_t det, dmag, nm, q, lim;
    logic neg;
    for (int i = 0; i < NUM_ELEM; i++) w[i] = m[i];
    for (int i = 0; i < NUM_ELEM; i++)
      cof[i] = w[COF_IDX[i][0]] * w[COF_IDX[i][1]] - w[COF_IDX[i][2]] * w[COF_IDX[i][3]];
    det = w[0] * cof[0] + w[1] * cof[3] + w[2] * cof[6];
    dmag = (det < 0) ? -det : det;
    r.invertible = 0;
    r.saturated = 0;
    for (int i = 0; i < NUM_ELEM; i++) r.inv[i] = '0;
    if (dmag <= (wide_t'(thr) <<< (2*FB))) return r;
    r.invertible = 1;
    for (int i = 0; i < NUM_ELEM; i++) begin
      neg = (cof[i] < 0) != (det < 0);
      nm = ((cof[i] < 0) ? -cof[i] : cof[i]) <<< (2*FB);
      q = ((nm <<< 1) + dmag) / (dmag <<< 1);
      lim = neg ? (wide_t'(1) <<< (EW-1)) : ((wide_t'(1) <<< (EW-1)) - 1);
      if (q > lim) begin
        r.saturated = 1;
        q = lim;
      end
      r.inv[i] = elem_t'(neg ? -q : q);
    end
    return r;
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
      2: return elem_t'($urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000);
      3: return '0;
      4: return elem_t'($signed($urandom_range(0, 64)) - 32);
      default: return elem_t'($signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
    endcase
  endfunction

  task automatic queue_matrix(mat_t m);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < NUM_ELEM; i++) d[i*EW +: EW] = m[i];
    pending_beats.push_back(d);
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: predict at the accepting edge, then offer the next beat
  always @(posedge clk) begin
    if (cycles > 0) begin
      if (in_tvalid && in_tready) begin
        mat_t m;
        for (int i = 0; i < NUM_ELEM; i++) m[i] = in_tdata[i*EW +: EW];
        expected_inverses.push_back(invert_matrix(m, threshold));
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 0;
        end else if (pending_beats.size() > 0 && rst_n) begin
          in_tdata <= pending_beats.pop_front();
          in_tvalid <= 1;
          in_gap <= pick_gap();
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    inverse_t e;
    cycles <= cycles + 1;
    if (out_tvalid && out_tready) begin
      n_recv++;
      if (expected_inverses.size() == 0) begin
        $error("unexpected output beat");
        errors++;
      end else begin
        e = expected_inverses.pop_front();
        if (!e.invertible) n_singular++;
        if (e.saturated) n_sat++;
        if (out_tuser[0] !== e.invertible) begin
          $error("invertible exp %0d got %0d", e.invertible, out_tuser[0]);
          errors++;
        end
        if (out_tuser[1] !== e.saturated) begin
          $error("saturated exp %0d got %0d", e.saturated, out_tuser[1]);
          errors++;
        end
        for (int i = 0; i < NUM_ELEM; i++)
          if (out_tdata[i*EW +: EW] !== e.inv[i]) begin
            $error("inv%0d%0d exp %0d got %0d", i/3, i%3, e.inv[i],
                   $signed(out_tdata[i*EW +: EW]));
            errors++;
          end
      end
    end
    // receiver backpressure, with one long hold-off
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else if (rst_n && !long_hold_done && n_sent >= 300) begin
      hold_off <= 200;
      long_hold_done <= 1;
      out_tready <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 0;
    end else begin
      out_tready <= rst_n;
      if (rst_n && $urandom_range(0, 3) == 0) out_gap <= pick_gap();
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_tvalid);
    @(posedge clk);
    wait (expected_inverses.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_WIDTH-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    threshold = v;
  endtask

  task automatic directed_set();
    mat_t m;
    // identity
    foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh1_0000 : 0;
    queue_matrix(m);
    // zero matrix
    foreach (m[i]) m[i] = 0;
    queue_matrix(m);
    // all max, all min: rank one, singular
    foreach (m[i]) m[i] = 32'sh7fff_ffff;
    queue_matrix(m);
    foreach (m[i]) m[i] = 32'sh8000_0000;
    queue_matrix(m);
    // diagonal extremes
    foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh8000_0000 : 0;
    queue_matrix(m);
    foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh7fff_ffff : 0;
    queue_matrix(m);
    // tiny diagonal: inverse saturates, and near threshold
    foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh1 : 0;
    queue_matrix(m);
    foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh100 : 0;
    queue_matrix(m);
    foreach (m[i]) m[i] = (i % 4 == 0) ? -32'sh200 : 0;
    queue_matrix(m);
    // negative identity, permutation, rounding ties
    foreach (m[i]) m[i] = (i % 4 == 0) ? -32'sh1_0000 : 0;
    queue_matrix(m);
    foreach (m[i]) m[i] = (i == 1 || i == 5 || i == 6) ? 32'sh3_0000 : 0;
    queue_matrix(m);
    foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh2_0000 : 0;
    queue_matrix(m);
    foreach (m[i]) m[i] = (i % 4 == 0) ? 32'sh3_0000 : 32'sh1_0000;
    queue_matrix(m);
    for (int k = 0; k < 8; k++) begin
      foreach (m[i]) m[i] = rand_elem();
      queue_matrix(m);
    end
  endtask

  task automatic random_set(int count);
    mat_t m;
    for (int k = 0; k < count; k++) begin
      foreach (m[i]) m[i] = rand_elem();
      // near-singular rows now and then
      if ($urandom_range(0, 7) == 0)
        for (int c = 0; c < 3; c++) m[6+c] = m[c] + elem_t'($urandom_range(0, 3));
      queue_matrix(m);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    directed_set();
    random_set(750);
    drain();
    write_threshold('0);
    directed_set();
    random_set(350);
    drain();
    write_threshold({THR_WIDTH{1'b1}});
    random_set(150);
    drain();
    write_threshold(31'h0001_0000);
    random_set(400);
    drain();
    write_threshold(31'd3);
    random_set(200);
    drain();
    stimulus_done = 1;
    $display("sent %0d matrices, checked %0d inverses", n_sent, n_recv);
    $display("%0d singular, %0d saturated, thresholds 7, 0, max, 1.0, 3",
             n_singular, n_sat);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
